/* hdl/tvad_pkg.sv */
// ----------------------------------------------------------------------------
// tvad_pkg: shared types and constants of the time-varying allpass delay
// Beat payloads, control groups passed between the submodules and fixed widths.
// ----------------------------------------------------------------------------
package tvad_pkg;

	localparam int SAMPLE_W = 16;
	localparam int DELAY_W  = 20;
	localparam int TAU_W    = DELAY_W + 1;
	localparam int FS_W     = 4;
	localparam int Y_W      = 26;
	localparam int DIST_W   = 18;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 20'd512;
	localparam logic [FS_W-1:0]    FS_RESET    = 4'd6;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [DELAY_W-1:0]         target_delay;
	} req_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_sample;
		logic                       out_of_range;
	} rsp_t;

	// Result of mapping a read distance onto the history ring.
	typedef struct packed {
		logic oor;
		logic blank;
	} fetch_flags_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic first;
	} mac_ctl_t;

endpackage

/* hdl/tvad_ram.sv */
// ----------------------------------------------------------------------------
// tvad_ram: generic single-port-write, single-port-read synchronous RAM
// Read data is registered and holds while no read is issued.
// ----------------------------------------------------------------------------
module tvad_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/tvad_addr.sv */
// ----------------------------------------------------------------------------
// tvad_addr: history distance to ring address
// Turns a distance back from the newest sample into a RAM index and flags
// reads outside the ring or of entries not yet written since reset.
// ----------------------------------------------------------------------------
module tvad_addr
	import tvad_pkg::*;
#(
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH),
	localparam int FW = $clog2(DEPTH + 1)
) (
	input  logic signed [DIST_W-1:0] span,
	input  logic [AW-1:0]            pos,
	input  logic [FW-1:0]            fill,
	output logic [AW-1:0]            idx,
	output fetch_flags_t             flags
);

	logic [AW:0] d_u;
	logic [AW:0] base;

	always_comb begin
		d_u = span[AW:0];
		flags.oor = (span < 0) || (span >= DIST_W'(DEPTH));
		// Writes run sequentially from index zero, so the last fill entries are the
		// only ones ever written.
		flags.blank = (d_u >= (AW+1)'(fill));
		if ({1'b0, pos} >= d_u) begin
			base = {1'b0, pos} - d_u;
		end else begin
			base = {1'b0, pos} + (AW+1)'(DEPTH) - d_u;
		end
		idx = base[AW-1:0];
	end

endmodule

/* hdl/tvad_mac.sv */
// ----------------------------------------------------------------------------
// tvad_mac: allpass multiply-accumulate
// Two registered steps: the coefficient product, then the sum, rounding and
// saturation into the stored last output.
// ----------------------------------------------------------------------------
module tvad_mac
	import tvad_pkg::*;
#(
	parameter int MAX_FRAME_SHIFT = 10,
	localparam int ALP_W = MAX_FRAME_SHIFT + 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mac_ctl_t                   ctl,
	input  logic signed [ALP_W-1:0]    alp,
	input  logic signed [SAMPLE_W-1:0] va,
	input  logic signed [SAMPLE_W-1:0] vb,
	output logic signed [Y_W-1:0]      y
);

	localparam int F      = MAX_FRAME_SHIFT + 8;
	localparam int DIFF_W = Y_W + 1;
	localparam int PROD_W = ALP_W + DIFF_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam logic signed [ACC_W-1:0] Y_HI = ACC_W'((1 << (Y_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] Y_LO = ACC_W'(-(1 << (Y_W - 1)));

	logic signed [DIFF_W-1:0]   diff;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [SAMPLE_W-1:0] va_s1;
	logic signed [SAMPLE_W-1:0] vb_s1;
	logic                       first_s1;
	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-1:0]    acc_sh;
	logic signed [Y_W-1:0]      y_next;
	logic signed [Y_W-1:0]      y_q;

	always_comb begin
		diff = (DIFF_W'(va) <<< 8) - DIFF_W'(y_q);
		prod = alp * diff;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			prod_s1  <= prod;
			va_s1    <= va;
			vb_s1    <= vb;
			first_s1 <= ctl.first;
		end
	end

	always_comb begin
		acc = ACC_W'(prod_s1) + (ACC_W'(vb_s1) <<< (8 + F)) + (ACC_W'(1) <<< (F - 1));
		acc_sh = acc >>> F;
		if (first_s1) begin
			// A frame's first item is a plain read with no interpolation.
			y_next = Y_W'(va_s1) <<< 8;
		end else if (acc_sh > Y_HI) begin
			y_next = Y_HI[Y_W-1:0];
		end else if (acc_sh < Y_LO) begin
			y_next = Y_LO[Y_W-1:0];
		end else begin
			y_next = acc_sh[Y_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q <= '0;
		end else if (ctl.load_s2) begin
			y_q <= y_next;
		end
	end

	assign y = y_q;

endmodule

/* hdl/time_varying_allpass_delay.sv */
// ----------------------------------------------------------------------------
// time_varying_allpass_delay: fractional delay line with a ramped allpass tap
// Flow: a beat passes MUL, RDA, RDB, MAC, ACC and OUT, where it may wait on
// rsp_stall; no new beat is taken before IDLE. Both history reads share the
// RAM's single read port in turn, then the two-step multiply-add follows.
// Reset: history reads as zero until written (tracked by a fill counter, no
// clearing pass); frame shift is 6 and both delays are two samples.
// ----------------------------------------------------------------------------
module time_varying_allpass_delay
	import tvad_pkg::*;
#(
	parameter int HISTORY_DEPTH   = 4096,
	parameter int MAX_FRAME_SHIFT = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  req_t            req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output rsp_t            rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [FS_W-1:0] cfg_data
);

	localparam int AW    = $clog2(HISTORY_DEPTH);
	localparam int FW    = $clog2(HISTORY_DEPTH + 1);
	localparam int FI_W  = MAX_FRAME_SHIFT;
	localparam int LEN_W = MAX_FRAME_SHIFT + 1;
	localparam int F     = MAX_FRAME_SHIFT + 8;
	localparam int ALP_W = MAX_FRAME_SHIFT + 10;
	localparam int P_W   = TAU_W + FI_W + 1;
	localparam int CEIL_W = DELAY_W - 7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RDA,
		ST_RDB,
		ST_MAC,
		ST_ACC,
		ST_OUT
	} state_t;

	state_t                     state_q;
	logic [FS_W-1:0]            frame_shift_q;
	logic [AW-1:0]              wp_q;
	logic [AW-1:0]              pos_q;
	logic [FW-1:0]              fill_q;
	logic [FI_W-1:0]            fi_q;
	logic [FI_W-1:0]            n_q;
	logic                       first_q;
	logic [FS_W-1:0]            fs_q;
	logic [DELAY_W-1:0]         prev_q;
	logic [DELAY_W-1:0]         cur_q;
	logic signed [TAU_W-1:0]    tau_q;
	logic signed [P_W-1:0]      p_q;
	logic signed [ALP_W-1:0]    alp_q;
	logic signed [DIST_W-1:0]   dist_b_q;
	logic signed [SAMPLE_W-1:0] va_q;
	fetch_flags_t               fa_q;
	fetch_flags_t               fb_q;
	logic                       bad_q;
	logic                       rsp_valid_q;
	rsp_t                       rsp_q;

	logic                       accept;
	logic [FS_W-1:0]            fs_eff;
	logic [LEN_W-1:0]           len;
	logic [FI_W-1:0]            fi_eff;
	logic [LEN_W-1:0]           fi_inc;
	logic [FI_W-1:0]            fi_nxt;
	logic                       first_now;
	logic [4:0]                 fbits;
	logic signed [P_W-1:0]      net;
	logic [P_W-1:0]             mask;
	logic [P_W-1:0]             frac_raw;
	logic [F-1:0]               frac;
	logic                       g0;
	logic                       g1;
	logic signed [ALP_W-1:0]    alp;
	logic [DELAY_W:0]           prev_rnd;
	logic [CEIL_W-1:0]          ceil_prev;
	logic signed [DIST_W-1:0]   dist_d;
	logic signed [DIST_W-1:0]   dist_a;
	logic signed [DIST_W-1:0]   dist_b;
	logic signed [DIST_W-1:0]   dist_sel;
	logic [AW-1:0]              ridx;
	fetch_flags_t               flags;
	logic                       ram_re;
	logic [SAMPLE_W-1:0]        rdata;
	logic signed [SAMPLE_W-1:0] vb;
	mac_ctl_t                   mac_ctl;
	logic signed [Y_W-1:0]      y;
	logic signed [Y_W:0]        y_rnd;
	logic signed [Y_W:0]        y_sh;
	logic signed [SAMPLE_W-1:0] out_sat;
	logic                       rsp_free;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// Frame bookkeeping at the input beat.
	always_comb begin
		if (frame_shift_q == '0) begin
			fs_eff = FS_W'(1);
		end else if (frame_shift_q > FS_W'(MAX_FRAME_SHIFT)) begin
			fs_eff = FS_W'(MAX_FRAME_SHIFT);
		end else begin
			fs_eff = frame_shift_q;
		end
		len = LEN_W'(1) << fs_eff;
		// A frame shift written mid-frame restarts the frame if the position is past its new end.
		fi_eff = ({1'b0, fi_q} >= len) ? '0 : fi_q;
		fi_inc = {1'b0, fi_eff} + LEN_W'(1);
		fi_nxt = (fi_inc >= len) ? '0 : fi_inc[FI_W-1:0];
		first_now = (fi_eff == '0);
	end

	// Read distances and allpass coefficient from the ramp product.
	always_comb begin
		fbits    = {1'b0, fs_q} + 5'd8;
		net      = p_q >>> fbits;
		mask     = (P_W'(1) << fbits) - P_W'(1);
		frac_raw = p_q & mask;
		frac     = frac_raw[F-1:0] << (FS_W'(MAX_FRAME_SHIFT) - fs_q);
		g1       = !tau_q[TAU_W-1];
		g0       = tau_q[TAU_W-1] && !first_q;
		if (g1) begin
			alp = $signed({2'b01, {F{1'b0}}}) - $signed({2'b00, frac});
		end else begin
			alp = -$signed({2'b00, frac});
		end
		prev_rnd  = {1'b0, prev_q} + (DELAY_W+1)'(255);
		ceil_prev = prev_rnd[DELAY_W:8];
		dist_d = $signed(DIST_W'(ceil_prev)) + $signed(net[DIST_W-1:0]);
		dist_a = dist_d - $signed({{(DIST_W-1){1'b0}}, g0});
		dist_b = dist_d + $signed({{(DIST_W-1){1'b0}}, g1});
		dist_sel = (state_q == ST_RDB) ? dist_b_q : dist_a;
	end

	tvad_addr #(
		.DEPTH (HISTORY_DEPTH)
	) u_addr (
		.span  (dist_sel),
		.pos   (pos_q),
		.fill  (fill_q),
		.idx   (ridx),
		.flags (flags)
	);

	// The sample is written at its input beat; both reads come later, so a read
	// never meets a write to the same entry.
	assign ram_re = (state_q == ST_RDA) || (state_q == ST_RDB);

	tvad_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (req.sample),
		.re    (ram_re),
		.raddr (ridx),
		.rdata (rdata)
	);

	always_comb begin
		vb = (fb_q.oor || fb_q.blank) ? '0 : $signed(rdata);
		mac_ctl.load_s1 = (state_q == ST_MAC);
		mac_ctl.load_s2 = (state_q == ST_ACC);
		mac_ctl.first   = first_q;
	end

	tvad_mac #(
		.MAX_FRAME_SHIFT (MAX_FRAME_SHIFT)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.alp    (alp_q),
		.va     (va_q),
		.vb     (vb),
		.y      (y)
	);

	always_comb begin
		y_rnd = (Y_W+1)'(y) + (Y_W+1)'(128);
		y_sh  = y_rnd >>> 8;
		if (y_sh > (Y_W+1)'(32767)) begin
			out_sat = 16'sh7fff;
		end else if (y_sh < -(Y_W+1)'(32768)) begin
			out_sat = 16'sh8000;
		end else begin
			out_sat = y_sh[SAMPLE_W-1:0];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q   <= wp_q;
			n_q     <= fi_eff;
			first_q <= first_now;
			fs_q    <= fs_eff;
		end
		if (state_q == ST_MUL) begin
			p_q <= tau_q * $signed({1'b0, n_q});
		end
		if (state_q == ST_RDA) begin
			alp_q    <= alp;
			dist_b_q <= dist_b;
			fa_q     <= flags;
		end
		if (state_q == ST_RDB) begin
			va_q  <= (fa_q.oor || fa_q.blank) ? '0 : $signed(rdata);
			fb_q  <= flags;
			bad_q <= fa_q.oor || (!first_q && flags.oor);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			frame_shift_q <= FS_RESET;
			wp_q          <= '0;
			fill_q        <= '0;
			fi_q          <= '0;
			prev_q        <= DELAY_RESET;
			cur_q         <= DELAY_RESET;
			tau_q         <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_q         <= '0;
		end else begin
			if (cfg_valid) begin
				frame_shift_q <= cfg_data;
			end
			if (rsp_valid_q && !rsp_stall && (state_q != ST_OUT)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wp_q <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
						if (fill_q != FW'(HISTORY_DEPTH)) begin
							fill_q <= fill_q + FW'(1);
						end
						fi_q <= fi_nxt;
						if (first_now) begin
							prev_q <= cur_q;
							cur_q  <= req.target_delay;
							tau_q  <= $signed({1'b0, req.target_delay}) - $signed({1'b0, cur_q});
						end
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_RDA;
				end
				ST_RDA: begin
					state_q <= ST_RDB;
				end
				ST_RDB: begin
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (rsp_free) begin
						rsp_valid_q        <= 1'b1;
						rsp_q.out_sample   <= out_sat;
						rsp_q.out_of_range <= bad_q;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("input accepted without the block going busy");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && !rsp_valid_q |=> rsp_valid_q && (state_q == ST_IDLE))
		else $error("finished item not moved to the output register");

	a_fill_counts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (fill_q != FW'(HISTORY_DEPTH)) |=> fill_q == $past(fill_q) + FW'(1))
		else $error("fill count did not follow the history writes");
`endif

endmodule

/* verif/time_varying_allpass_delay_tb.sv */
// ----------------------------------------------------------------------------
// time_varying_allpass_delay_tb: self-checking bench for the ramped delay line
// A stimulus table walks the frame starts, the far ends of the delay range,
// out-of-history reads and clamped frame shifts. Random phases with fresh
// frame shifts follow. Every output beat is checked against a local model or a table value.
// ----------------------------------------------------------------------------
module time_varying_allpass_delay_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tvad_pkg::*;

	localparam int     HIST_DEPTH   = 4096;
	localparam int     MAX_SHIFT    = 10;
	localparam int     FRAC_BITS    = MAX_SHIFT + 8;
	localparam longint Y_HI         = 64'sd33554431;
	localparam longint Y_LO         = -64'sd33554432;
	localparam int     RANDOM_ITEMS = 1850;
	localparam int     STALL_LIMIT  = 2000;
	// Frame shifts of the first random phases, phase 0 in the low nibble.
	localparam logic [63:0] SHIFT_PLAN = 64'hEDC86593B7140F2A;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [DELAY_W-1:0]         target;
		bit                         set_shift;
		logic [FS_W-1:0]            shift;
		bit                         typed;
		logic signed [SAMPLE_W-1:0] want_sample;
		bit                         want_oor;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b1;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [FS_W-1:0] cfg_data = '0;

	bit steady = 1'b0;
	int mismatch_count = 0;
	int idle_cycles = 0;
	step_row_t directed_steps[$];
	rsp_t pending_outputs[$];

	// Model state.
	logic signed [SAMPLE_W-1:0] tap_history [HIST_DEPTH];
	int write_ptr = 0;
	int frame_pos = 0;
	logic [DELAY_W-1:0] start_delay = DELAY_RESET;
	logic [DELAY_W-1:0] end_delay = DELAY_RESET;
	longint ramp = 0;
	longint last_y = 0;
	logic [FS_W-1:0] fs_setting = FS_RESET;
	bit range_miss;

	time_varying_allpass_delay #(
		.HISTORY_DEPTH  (HIST_DEPTH),
		.MAX_FRAME_SHIFT(MAX_SHIFT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < HIST_DEPTH; i++) begin
			tap_history[i] = '0;
		end
	end

	function automatic longint fetch_back(longint span);
		if (span < 0 || span >= HIST_DEPTH) begin
			range_miss = 1'b1;
			return 0;
		end
		return longint'(tap_history[(write_ptr + HIST_DEPTH - int'(span)) % HIST_DEPTH]);
	endfunction

	function automatic rsp_t predict_delayed_sample(req_t item);
		int shift;
		int frame_len;
		int fbits;
		longint p, net, frac, alp, d, va, vb, acc, y, outv, g0, g1;
		rsp_t r;
		shift = (fs_setting < 1) ? 1 : ((fs_setting > MAX_SHIFT) ? MAX_SHIFT : int'(fs_setting));
		frame_len = 1 << shift;
		tap_history[write_ptr] = item.sample;
		range_miss = 1'b0;
		if (frame_pos >= frame_len) begin
			frame_pos = 0;
		end
		if (frame_pos == 0) begin
			start_delay = end_delay;
			end_delay = item.target_delay;
			ramp = longint'(end_delay) - longint'(start_delay);
			y = fetch_back((longint'(start_delay) + 255) >>> 8) * 256;
		end else begin
			fbits = shift + 8;
			p = ramp * longint'(frame_pos);
			net = p >>> fbits;
			// The fraction is widened to the fixed coefficient format.
			frac = (p & ((64'sd1 << fbits) - 1)) << (FRAC_BITS - fbits);
			g0 = (ramp < 0) ? 1 : 0;
			g1 = 1 - g0;
			alp = (g1 << FRAC_BITS) - frac;
			d = ((longint'(start_delay) + 255) >>> 8) + net;
			va = fetch_back(d - g0);
			vb = fetch_back(d + g1);
			acc = alp * (va * 256 - last_y) + vb * 256 * (64'sd1 << FRAC_BITS);
			y = (acc + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
		end
		if (y > Y_HI) begin
			y = Y_HI;
		end else if (y < Y_LO) begin
			y = Y_LO;
		end
		last_y = y;
		outv = (y + 128) >>> 8;
		if (outv > 32767) begin
			outv = 32767;
		end else if (outv < -32768) begin
			outv = -32768;
		end
		frame_pos++;
		if (frame_pos >= frame_len) begin
			frame_pos = 0;
		end
		write_ptr = (write_ptr + 1) % HIST_DEPTH;
		r.out_sample = outv[SAMPLE_W-1:0];
		r.out_of_range = range_miss;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("ERROR at %0t: %s", $time, what);
	endtask

	task automatic add_step(logic signed [SAMPLE_W-1:0] sample, logic [DELAY_W-1:0] target,
			bit set_shift, logic [FS_W-1:0] shift, bit typed,
			logic signed [SAMPLE_W-1:0] want_sample, bit want_oor);
		step_row_t row;
		row.sample = sample;
		row.target = target;
		row.set_shift = set_shift;
		row.shift = shift;
		row.typed = typed;
		row.want_sample = want_sample;
		row.want_oor = want_oor;
		directed_steps.push_back(row);
	endtask

	// Called at a rising edge; returns at the edge that accepts the beat.
	task automatic send_item(req_t item, bit typed, logic signed [SAMPLE_W-1:0] want_sample,
			bit want_oor);
		rsp_t expected;
		while (!steady && $urandom_range(0, 99) < 23) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(negedge clk);
		while (req_stall) begin
			@(negedge clk);
		end
		@(posedge clk);
		expected = predict_delayed_sample(item);
		if (typed) begin
			expected.out_sample = want_sample;
			expected.out_of_range = want_oor;
		end
		pending_outputs.push_back(expected);
	endtask

	// The block has to be idle, so the input side drains before the write.
	task automatic write_frame_shift(logic [FS_W-1:0] value);
		req_valid <= 1'b0;
		while (pending_outputs.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		while (!cfg_ready) begin
			@(negedge clk);
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
		fs_setting = value;
	endtask

	always @(posedge clk) begin
		rsp_stall <= !steady && ($urandom_range(0, 99) < 23);
	end

	// Handshakes are judged at the falling edge, where every signal is settled.
	rsp_t want;
	always @(negedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch($sformatf("output beat with nothing expected: %0d/%0b",
					rsp.out_sample, rsp.out_of_range));
			end else begin
				want = pending_outputs.pop_front();
				if (rsp.out_sample !== want.out_sample) begin
					report_mismatch($sformatf("out_sample got %0d want %0d",
						rsp.out_sample, want.out_sample));
				end
				if (rsp.out_of_range !== want.out_of_range) begin
					report_mismatch($sformatf("out_of_range got %0b want %0b",
						rsp.out_of_range, want.out_of_range));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
					|| (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		req_t item;
		step_row_t row;
		int items_left;
		int phase;
		int count;
		logic [FS_W-1:0] shift;

		// Two-sample frames make every other item a frame start.
		// First start after reset reads a slot that was never written.
		add_step(16'sd32767, 20'd0, 1'b1, 4'd1, 1'b1, 16'sd0, 1'b0);
		add_step(-16'sd32768, 20'hFFFFF, 1'b0, 4'd0, 1'b0, 16'sd0, 1'b0);
		// Delay zero reads the sample of the same beat.
		add_step(-16'sd32768, 20'hFFFFF, 1'b0, 4'd0, 1'b1, -16'sd32768, 1'b0);
		add_step(16'sd100, 20'd0, 1'b0, 4'd0, 1'b0, 16'sd0, 1'b0);
		// The largest delay is one past the end of the history.
		add_step(-16'sd1, 20'd0, 1'b0, 4'd0, 1'b1, 16'sd0, 1'b1);
		add_step(16'sd500, 20'd0, 1'b0, 4'd0, 1'b0, 16'sd0, 1'b0);
		add_step(16'sd0, 20'd256, 1'b0, 4'd0, 1'b1, 16'sd0, 1'b0);
		add_step(16'sd12345, 20'd77, 1'b0, 4'd0, 1'b0, 16'sd0, 1'b0);
		add_step(-16'sd20000, 20'd1, 1'b0, 4'd0, 1'b1, 16'sd12345, 1'b0);
		// Shrinking delay near zero reaches a future sample.
		add_step(-16'sd7, 20'd0, 1'b0, 4'd0, 1'b0, 16'sd0, 1'b0);
		add_step(16'sd9, 20'd300, 1'b0, 4'd0, 1'b1, -16'sd7, 1'b0);
		// A shift above the maximum is clamped, so these stay inside one frame.
		add_step(16'sd2000, 20'd999999, 1'b1, 4'd15, 1'b0, 16'sd0, 1'b0);
		add_step(-16'sd3000, 20'd5, 1'b0, 4'd0, 1'b0, 16'sd0, 1'b0);
		add_step(16'sd31000, 20'd6, 1'b0, 4'd0, 1'b0, 16'sd0, 1'b0);
		add_step(16'sd4, 20'd7, 1'b0, 4'd0, 1'b0, 16'sd0, 1'b0);
		// Shift zero clamps to one; the frame position is past the new length,
		// so this beat starts a frame at two samples back.
		add_step(16'sd8, 20'd1000, 1'b1, 4'd0, 1'b1, 16'sd31000, 1'b0);
		add_step(-16'sd32768, 20'd0, 1'b0, 4'd0, 1'b0, 16'sd0, 1'b0);
		add_step(16'sd32767, 20'd2, 1'b0, 4'd0, 1'b0, 16'sd0, 1'b0);
		add_step(16'sd32767, 20'd0, 1'b0, 4'd0, 1'b0, 16'sd0, 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			row = directed_steps[i];
			if (row.set_shift) begin
				write_frame_shift(row.shift);
			end
			item.sample = row.sample;
			item.target_delay = row.target;
			send_item(item, row.typed, row.want_sample, row.want_oor);
		end

		items_left = RANDOM_ITEMS;
		phase = 0;
		while (items_left > 0) begin
			shift = (phase < 16) ? SHIFT_PLAN[phase*4 +: 4] : 4'($urandom_range(0, 15));
			write_frame_shift(shift);
			steady <= (phase == 3);
			count = (phase == 3) ? 200 : $urandom_range(40, 250);
			if (count > items_left) begin
				count = items_left;
			end
			for (int k = 0; k < count; k++) begin
				case ($urandom_range(0, 9))
					0, 1: item.sample = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
					2, 3: item.sample = 16'($urandom_range(0, 200)) - 16'sd100;
					default: item.sample = 16'($urandom);
				endcase
				case ($urandom_range(0, 19))
					0: item.target_delay = 20'd0;
					1: item.target_delay = 20'hFFFFF;
					2: item.target_delay = 20'd1048320;
					3, 4, 5: item.target_delay = 20'($urandom);
					6, 7, 8, 9, 10: item.target_delay = 20'($urandom_range(0, 1048320));
					default: item.target_delay = 20'($urandom_range(0, 24 * 256));
				endcase
				send_item(item, 1'b0, 16'sd0, 1'b0);
			end
			items_left -= count;
			phase++;
		end

		req_valid <= 1'b0;
		steady <= 1'b0;
		while (pending_outputs.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_outputs.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
